### src/adts_pkg.sv
// shared types and constants for the adts frame deframer
// covers controller states, command and status bundles and the time step table
// no dependencies
package adts_pkg;

  // header byte codes and limits
  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam logic [7:0] SECOND_MASK  = 8'hF6;
  localparam logic [7:0] SECOND_MATCH = 8'hF0;
  localparam logic [3:0] MAX_SRI      = 4'd11;
  localparam logic [12:0] MIN_LEN     = 13'd8;

  // header handling counts
  localparam int unsigned CNT_W = 3;
  localparam logic [CNT_W-1:0] HDR_LAST     = 3'd7;
  localparam logic [CNT_W-1:0] RESCAN_BYTES = 3'd6;
  localparam int unsigned HDR_BYTES = 8;

  // sample rates in Hz per index
  localparam longint unsigned R0  = 96000;
  localparam longint unsigned R1  = 88200;
  localparam longint unsigned R2  = 64000;
  localparam longint unsigned R3  = 48000;
  localparam longint unsigned R4  = 44100;
  localparam longint unsigned R5  = 32000;
  localparam longint unsigned R6  = 24000;
  localparam longint unsigned R7  = 22050;
  localparam longint unsigned R8  = 16000;
  localparam longint unsigned R9  = 12000;
  localparam longint unsigned R10 = 11025;
  localparam longint unsigned R11 = 8000;

  // 1024 samples with 32 fraction bits
  localparam longint unsigned T42 = 64'd1 << 42;

  // time step per rate index and block code: round(blocks * 2^42 / rate)
  localparam logic [31:0] INC_TABLE [16][4] = '{
    '{32'((T42 + R0/2) / R0), 32'((2*T42 + R0/2) / R0),
      32'((3*T42 + R0/2) / R0), 32'((4*T42 + R0/2) / R0)},
    '{32'((T42 + R1/2) / R1), 32'((2*T42 + R1/2) / R1),
      32'((3*T42 + R1/2) / R1), 32'((4*T42 + R1/2) / R1)},
    '{32'((T42 + R2/2) / R2), 32'((2*T42 + R2/2) / R2),
      32'((3*T42 + R2/2) / R2), 32'((4*T42 + R2/2) / R2)},
    '{32'((T42 + R3/2) / R3), 32'((2*T42 + R3/2) / R3),
      32'((3*T42 + R3/2) / R3), 32'((4*T42 + R3/2) / R3)},
    '{32'((T42 + R4/2) / R4), 32'((2*T42 + R4/2) / R4),
      32'((3*T42 + R4/2) / R4), 32'((4*T42 + R4/2) / R4)},
    '{32'((T42 + R5/2) / R5), 32'((2*T42 + R5/2) / R5),
      32'((3*T42 + R5/2) / R5), 32'((4*T42 + R5/2) / R5)},
    '{32'((T42 + R6/2) / R6), 32'((2*T42 + R6/2) / R6),
      32'((3*T42 + R6/2) / R6), 32'((4*T42 + R6/2) / R6)},
    '{32'((T42 + R7/2) / R7), 32'((2*T42 + R7/2) / R7),
      32'((3*T42 + R7/2) / R7), 32'((4*T42 + R7/2) / R7)},
    '{32'((T42 + R8/2) / R8), 32'((2*T42 + R8/2) / R8),
      32'((3*T42 + R8/2) / R8), 32'((4*T42 + R8/2) / R8)},
    '{32'((T42 + R9/2) / R9), 32'((2*T42 + R9/2) / R9),
      32'((3*T42 + R9/2) / R9), 32'((4*T42 + R9/2) / R9)},
    '{32'((T42 + R10/2) / R10), 32'((2*T42 + R10/2) / R10),
      32'((3*T42 + R10/2) / R10), 32'((4*T42 + R10/2) / R10)},
    '{32'((T42 + R11/2) / R11), 32'((2*T42 + R11/2) / R11),
      32'((3*T42 + R11/2) / R11), 32'((4*T42 + R11/2) / R11)},
    '{32'd0, 32'd0, 32'd0, 32'd0},
    '{32'd0, 32'd0, 32'd0, 32'd0},
    '{32'd0, 32'd0, 32'd0, 32'd0},
    '{32'd0, 32'd0, 32'd0, 32'd0}
  };

  // controller states
  typedef enum logic [2:0] {
    ST_SEEK,
    ST_CHECK,
    ST_FILL,
    ST_EMIT,
    ST_PASS
  } state_e;

  // header store operations
  typedef enum logic [1:0] {
    HOP_NONE,
    HOP_START,
    HOP_APPEND
  } hunt_op_e;

  // fields decoded from one header
  typedef struct packed {
    logic        mpeg_version;
    logic [1:0]  block_code;
    logic [3:0]  sample_rate_index;
    logic [12:0] frame_length;
  } frame_t;

  // controller to datapath
  typedef struct packed {
    logic     use_replay;
    hunt_op_e hop;
    logic     load_hdr;
    logic     load_rescan;
    logic     shift_replay;
    logic     take_frame;
    logic     pass_byte;
    logic     out_load;
    logic     out_from_replay;
    logic     out_first;
    logic     out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic byte_is_sync;
    logic byte_second_ok;
    logic fill_last;
    logic header_ok;
    logic len_is_min;
    logic left_is_one;
    logic out_free;
  } sts_t;

endpackage

### src/adts_datapath.sv
// datapath of the adts frame deframer: header store, replay line, frame
// registers, time accumulator and output register
// depends on adts_pkg
module adts_datapath #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  adts_pkg::cmd_t        cmd_i,
  output adts_pkg::sts_t        sts_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [7:0]            out_byte_o,
  output logic                  first_of_frame_o,
  output logic                  last_of_frame_o,
  output logic [12:0]           frame_length_o,
  output logic [3:0]            sample_rate_index_o,
  output logic [2:0]            block_count_o,
  output logic                  mpeg_version_o,
  output logic [TIME_WIDTH-1:0] end_time_o
);
  import adts_pkg::*;

  logic [7:0]            hdr_q [HDR_BYTES];
  logic [7:0]            replay_q [HDR_BYTES];
  logic [7:0]            replay_d [HDR_BYTES];
  logic [CNT_W-1:0]      fill_q, fill_d;
  logic [12:0]           left_q, left_d;
  frame_t                frame_q, frame_d;
  logic [TIME_WIDTH-1:0] elapsed_q, elapsed_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_byte_q;
  logic                  out_first_q, out_last_q;
  frame_t                out_frame_q;
  logic [TIME_WIDTH-1:0] out_time_q;
  logic [7:0]            cur_byte;
  frame_t                hdr_frame;

  // byte source: input or replayed header byte
  assign cur_byte = cmd_i.use_replay ? replay_q[0] : data_byte_i;

  // header decode from fixed store positions
  assign hdr_frame.mpeg_version      = hdr_q[1][3];
  assign hdr_frame.block_code        = hdr_q[6][1:0];
  assign hdr_frame.sample_rate_index = hdr_q[2][5:2];
  assign hdr_frame.frame_length      = {hdr_q[3][1:0], hdr_q[4], hdr_q[5][7:5]};

  // status to controller
  assign sts_o.byte_is_sync   = (cur_byte == SYNC_BYTE);
  assign sts_o.byte_second_ok = ((cur_byte & SECOND_MASK) == SECOND_MATCH);
  assign sts_o.fill_last      = (fill_q == HDR_LAST);
  assign sts_o.header_ok      = (hdr_frame.sample_rate_index <= MAX_SRI)
                             && (hdr_frame.frame_length >= MIN_LEN);
  assign sts_o.len_is_min     = (frame_q.frame_length == MIN_LEN);
  assign sts_o.left_is_one    = (left_q == 13'd1);
  assign sts_o.out_free       = !out_valid_q || !out_stall_i;

  // header store, written at position 0 on start, else at the fill position
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      if ((cmd_i.hop == HOP_START && i == 0)
          || (cmd_i.hop == HOP_APPEND && fill_q == CNT_W'(i))) begin
        hdr_q[i] <= cur_byte;
      end
    end
  end

  // fill count
  always_comb begin
    fill_d = fill_q;
    case (cmd_i.hop)
      HOP_START:  fill_d = CNT_W'(1);
      HOP_APPEND: fill_d = fill_q + CNT_W'(1);
      default:    fill_d = fill_q;
    endcase
  end

  // replay line: whole header for emission or bytes 2..7 for rescan
  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      replay_d[i] = replay_q[i];
    end
    if (cmd_i.load_hdr) begin
      for (int i = 0; i < HDR_BYTES - 1; i++) begin
        replay_d[i] = hdr_q[i];
      end
      replay_d[HDR_BYTES-1] = cur_byte;
    end else if (cmd_i.load_rescan) begin
      for (int i = 0; i < HDR_BYTES - 3; i++) begin
        replay_d[i] = hdr_q[i+2];
      end
      replay_d[HDR_BYTES-3] = cur_byte;
    end else if (cmd_i.shift_replay) begin
      for (int i = 0; i < HDR_BYTES - 1; i++) begin
        replay_d[i] = replay_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      replay_q[i] <= replay_d[i];
    end
  end

  // frame registers, payload count and time accumulator
  always_comb begin
    frame_d   = frame_q;
    left_d    = left_q;
    elapsed_d = elapsed_q;
    if (cmd_i.take_frame) begin
      frame_d   = hdr_frame;
      left_d    = hdr_frame.frame_length - MIN_LEN;
      elapsed_d = elapsed_q + TIME_WIDTH'(
        INC_TABLE[hdr_frame.sample_rate_index][hdr_frame.block_code]);
    end else if (cmd_i.pass_byte) begin
      left_d = left_q - 13'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      left_q    <= '0;
      frame_q   <= '0;
      elapsed_q <= '0;
    end else begin
      fill_q    <= fill_d;
      left_q    <= left_d;
      frame_q   <= frame_d;
      elapsed_q <= elapsed_d;
    end
  end

  // output register valid
  assign out_valid_d = cmd_i.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_byte_q  <= cmd_i.out_from_replay ? replay_q[0] : data_byte_i;
      out_first_q <= cmd_i.out_first;
      out_last_q  <= cmd_i.out_last;
      out_frame_q <= frame_q;
      out_time_q  <= elapsed_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_byte_o          = out_byte_q;
  assign first_of_frame_o    = out_first_q;
  assign last_of_frame_o     = out_last_q;
  assign frame_length_o      = out_frame_q.frame_length;
  assign sample_rate_index_o = out_frame_q.sample_rate_index;
  assign block_count_o       = {1'b0, out_frame_q.block_code} + 3'd1;
  assign mpeg_version_o      = out_frame_q.mpeg_version;
  assign end_time_o          = out_time_q;

endmodule

### src/adts_controller.sv
// controller of the adts frame deframer: sync hunt, header check,
// header emission, rescan and payload pass-through
// depends on adts_pkg
module adts_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  adts_pkg::sts_t sts_i,
  output adts_pkg::cmd_t cmd_o
);
  import adts_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             replay;
  logic             byte_go;

  // state and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SEEK;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // in hunt states a nonzero count means rescan bytes still pending
  assign replay  = (cnt_q != '0);
  assign byte_go = replay || in_valid_i;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.hop  = HOP_NONE;
    in_stall_o = 1'b1;
    case (state_q)
      ST_SEEK, ST_CHECK, ST_FILL: begin
        cmd_o.use_replay = replay;
        in_stall_o       = replay;
        if (byte_go) begin
          if (replay) begin
            cmd_o.shift_replay = 1'b1;
            cnt_d              = cnt_q - CNT_W'(1);
          end
          case (state_q)
            ST_SEEK: begin
              if (sts_i.byte_is_sync) begin
                cmd_o.hop = HOP_START;
                state_d   = ST_CHECK;
              end
            end
            ST_CHECK: begin
              if (sts_i.byte_second_ok) begin
                cmd_o.hop = HOP_APPEND;
                state_d   = ST_FILL;
              end else begin
                state_d = ST_SEEK;
              end
            end
            default: begin
              cmd_o.hop = HOP_APPEND;
              // last header byte: accept the frame or rescan bytes 2..7
              if (sts_i.fill_last) begin
                if (sts_i.header_ok) begin
                  cmd_o.load_hdr   = 1'b1;
                  cmd_o.take_frame = 1'b1;
                  cnt_d            = '0;
                  state_d          = ST_EMIT;
                end else begin
                  cmd_o.load_rescan = 1'b1;
                  cnt_d             = RESCAN_BYTES;
                  state_d           = ST_SEEK;
                end
              end
            end
          endcase
        end
      end
      ST_EMIT: begin
        // header bytes out of the replay line, one per free output slot
        if (sts_i.out_free) begin
          cmd_o.out_load        = 1'b1;
          cmd_o.out_from_replay = 1'b1;
          cmd_o.out_first       = (cnt_q == '0);
          cmd_o.out_last        = (cnt_q == HDR_LAST) && sts_i.len_is_min;
          cmd_o.shift_replay    = 1'b1;
          cnt_d                 = cnt_q + CNT_W'(1);
          if (cnt_q == HDR_LAST) begin
            state_d = sts_i.len_is_min ? ST_SEEK : ST_PASS;
          end
        end
      end
      ST_PASS: begin
        // payload bytes straight to the output register
        in_stall_o = !sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_last  = sts_i.left_is_one;
          cmd_o.pass_byte = 1'b1;
          if (sts_i.left_is_one) begin
            state_d = ST_SEEK;
          end
        end
      end
      default: begin
        state_d = ST_SEEK;
        cnt_d   = '0;
      end
    endcase
  end

endmodule

### src/adts_frame_deframer_unit.sv
// top level of the adts frame deframer: controller plus datapath
// depends on adts_pkg, adts_controller and adts_datapath
//
//   channel   direction  handshake              payload
//   input     in         in_valid_i/in_stall_o  data_byte_i
//   output    out        out_valid_o/out_stall_i out_byte_o and frame fields
//
// sync, second and header bytes are taken one per cycle while no rescan is replaying
// after the eighth header byte the input stalls while the header is sent from a
//   replay line; a bad header stalls it while bytes 2..7 are rescanned
// payload bytes pass one per cycle while the output register is free
// output stall holds the output register and, in pass-through, the input
// reset clears state, counts, frame fields and elapsed time
module adts_frame_deframer_unit #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  first_of_frame_o,
  output logic                  last_of_frame_o,
  output logic [12:0]           frame_length_o,
  output logic [3:0]            sample_rate_index_o,
  output logic [2:0]            block_count_o,
  output logic                  mpeg_version_o,
  output logic [TIME_WIDTH-1:0] end_time_o
);
  import adts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  adts_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and arithmetic
  adts_datapath #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .data_byte_i         (data_byte_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .out_byte_o          (out_byte_o),
    .first_of_frame_o    (first_of_frame_o),
    .last_of_frame_o     (last_of_frame_o),
    .frame_length_o      (frame_length_o),
    .sample_rate_index_o (sample_rate_index_o),
    .block_count_o       (block_count_o),
    .mpeg_version_o      (mpeg_version_o),
    .end_time_o          (end_time_o)
  );

endmodule

### src/adts_checker.sv
// port-level checks for the adts frame deframer
// attached to adts_frame_deframer_unit by the bind at the end of this file
module adts_checker #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [7:0]            out_byte_o,
  input logic                  first_of_frame_o,
  input logic                  last_of_frame_o,
  input logic [12:0]           frame_length_o,
  input logic [3:0]            sample_rate_index_o,
  input logic [2:0]            block_count_o,
  input logic                  mpeg_version_o,
  input logic [TIME_WIDTH-1:0] end_time_o
);

  // a stalled request stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
  else $error("output request dropped under stall");

  // a stalled request keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable({out_byte_o, first_of_frame_o, last_of_frame_o,
                                            frame_length_o, sample_rate_index_o,
                                            block_count_o, mpeg_version_o, end_time_o}))
  else $error("output payload changed under stall");

  // every emitted byte belongs to a header that passed the checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_length_o >= 13'd8) && (sample_rate_index_o <= 4'd11))
  else $error("byte emitted for an invalid header");

  // a frame is at least a header long, so its first byte is never its last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_of_frame_o |-> !last_of_frame_o)
  else $error("first byte also marked last");

  // the byte after a frame start, once taken, is not another frame start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && first_of_frame_o ##1 out_valid_o
      |-> !first_of_frame_o)
  else $error("two frame starts in a row");

endmodule

bind adts_frame_deframer_unit adts_checker #(
  .TIME_WIDTH (TIME_WIDTH)
) u_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .out_byte_o          (out_byte_o),
  .first_of_frame_o    (first_of_frame_o),
  .last_of_frame_o     (last_of_frame_o),
  .frame_length_o      (frame_length_o),
  .sample_rate_index_o (sample_rate_index_o),
  .block_count_o       (block_count_o),
  .mpeg_version_o      (mpeg_version_o),
  .end_time_o          (end_time_o)
);

### verif/tb_adts_frame_deframer_unit.sv
// testbench for adts_frame_deframer_unit: byte stream in, framed bytes out
// a scoreboard class predicts each output beat from the accepted input bytes
// depends on adts_pkg and the adts_frame_deframer_unit rtl
module tb_adts_frame_deframer_unit;
  import adts_pkg::*;

  localparam int unsigned TW = 48;

  // hunt phases of the predictor
  typedef enum logic [1:0] {
    HUNT_SEEK,
    HUNT_CHECK,
    HUNT_FILL,
    HUNT_PASS
  } hunt_e;

  // one output beat with its frame fields
  typedef struct packed {
    logic [7:0]    data;
    logic          sof;
    logic          eof;
    logic [12:0]   len;
    logic [3:0]    sri;
    logic [2:0]    blocks;
    logic          ver;
    logic [TW-1:0] end_t;
  } beat_t;

  // deframer predictor and queue of beats still owed by the block
  class frame_scoreboard;
    hunt_e           phase;
    logic [7:0]      hdr [8];
    int unsigned     fill;
    logic [12:0]     left;
    logic [12:0]     f_len;
    logic [3:0]      f_sri;
    logic [1:0]      f_code;
    logic            f_ver;
    logic [TW-1:0]   elapsed;
    longint unsigned rate_hz [12];
    beat_t           beats_due [$];
    int unsigned     errors, reported, beats_seen, bytes_taken;
    int unsigned     frames_ok, hdr_rejects, seconds_dropped;

    function new();
      rate_hz = '{96000, 88200, 64000, 48000, 44100, 32000,
                  24000, 22050, 16000, 12000, 11025, 8000};
      phase = HUNT_SEEK;
      fill = 0;
      left = '0;
      f_len = '0;
      f_sri = '0;
      f_code = '0;
      f_ver = 1'b0;
      elapsed = '0;
      errors = 0;
      reported = 0;
      beats_seen = 0;
      bytes_taken = 0;
      frames_ok = 0;
      hdr_rejects = 0;
      seconds_dropped = 0;
    endfunction

    // sync search and header buffering
    function void hunt(logic [7:0] b);
      case (phase)
        HUNT_SEEK: begin
          if (b == SYNC_BYTE) begin
            hdr[0] = b;
            fill = 1;
            phase = HUNT_CHECK;
          end
        end
        HUNT_CHECK: begin
          if ((b & SECOND_MASK) == SECOND_MATCH) begin
            hdr[1] = b;
            fill = 2;
            phase = HUNT_FILL;
          end else begin
            fill = 0;
            phase = HUNT_SEEK;
            seconds_dropped++;
          end
        end
        default: begin
          hdr[fill % 8] = b;
          fill = (fill + 1) % 16;
        end
      endcase
    endfunction

    function void push(logic [7:0] b, logic sof, logic eof);
      beat_t e;
      e.data = b;
      e.sof = sof;
      e.eof = eof;
      e.len = f_len;
      e.sri = f_sri;
      e.blocks = {1'b0, f_code} + 3'd1;
      e.ver = f_ver;
      e.end_t = elapsed;
      beats_due.push_back(e);
    endfunction

    // note one accepted input request and queue the beats it causes
    function void take_byte(logic [7:0] b);
      logic [7:0]      rescan [6];
      logic [3:0]      sri;
      logic [12:0]     len;
      longint unsigned inc;
      bytes_taken++;
      if (phase == HUNT_PASS) begin
        left--;
        push(b, 1'b0, left == 0);
        if (left == 0) phase = HUNT_SEEK;
        return;
      end
      hunt(b);
      if (phase != HUNT_FILL || fill < 8) return;
      sri = hdr[2][5:2];
      len = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
      // bad header: restart the hunt over buffered bytes 2..7
      if (sri > MAX_SRI || len < MIN_LEN) begin
        hdr_rejects++;
        for (int k = 0; k < 6; k++) rescan[k] = hdr[k + 2];
        phase = HUNT_SEEK;
        fill = 0;
        for (int k = 0; k < 6; k++) hunt(rescan[k]);
        return;
      end
      f_ver = hdr[1][3];
      f_code = hdr[6][1:0];
      f_len = len;
      f_sri = sri;
      // blocks * 1024 / rate with 32 fraction bits, rounded half up
      inc = ((64'(f_code) + 64'd1) << 42) + rate_hz[sri] / 2;
      inc = inc / rate_hz[sri];
      elapsed = elapsed + inc[TW-1:0];
      for (int k = 0; k < 8; k++) push(hdr[k], k == 0, k == 7 && len == MIN_LEN);
      frames_ok++;
      fill = 0;
      if (len == MIN_LEN) begin
        phase = HUNT_SEEK;
        left = '0;
      end else begin
        phase = HUNT_PASS;
        left = len - MIN_LEN;
      end
    endfunction

    // compare one accepted output beat with the oldest prediction
    function void check_beat(beat_t got);
      beat_t want;
      beats_seen++;
      if (beats_due.size() == 0) begin
        errors++;
        if (reported < 10)
          $display("%0t: unexpected beat data %h sof %b eof %b len %0d sri %0d blk %0d ver %b t %h",
                   $time, got.data, got.sof, got.eof, got.len, got.sri, got.blocks, got.ver,
                   got.end_t);
        reported++;
        return;
      end
      want = beats_due.pop_front();
      if (got !== want) begin
        errors++;
        if (reported < 10) begin
          $display("%0t: beat mismatch", $time);
          $display("  exp data %h sof %b eof %b len %0d sri %0d blk %0d ver %b t %h",
                   want.data, want.sof, want.eof, want.len, want.sri, want.blocks, want.ver,
                   want.end_t);
          $display("  got data %h sof %b eof %b len %0d sri %0d blk %0d ver %b t %h",
                   got.data, got.sof, got.eof, got.len, got.sri, got.blocks, got.ver,
                   got.end_t);
        end
        reported++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [7:0]    data_in = 8'h00;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [7:0]    out_byte;
  logic          sof, eof;
  logic [12:0]   frame_len;
  logic [3:0]    rate_idx;
  logic [2:0]    blocks;
  logic          mpeg_ver;
  logic [TW-1:0] end_time;

  frame_scoreboard sb;
  int unsigned     sender_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     items_sent = 0;
  logic [7:0]      hb [8];

  adts_frame_deframer_unit #(
    .TIME_WIDTH(TW)
  ) uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .data_byte_i        (data_in),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_byte_o         (out_byte),
    .first_of_frame_o   (sof),
    .last_of_frame_o    (eof),
    .frame_length_o     (frame_len),
    .sample_rate_index_o(rate_idx),
    .block_count_o      (blocks),
    .mpeg_version_o     (mpeg_ver),
    .end_time_o         (end_time)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb_adts_frame_deframer_unit: FAIL");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // output beat check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_beat(beat_t'{out_byte, sof, eof, frame_len, rate_idx, blocks, mpeg_ver,
                            end_time});
  end

  // one input request, with optional idle cycles before it
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    data_in <= b;
    do @(posedge clk); while (in_stall);
    sb.take_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  // header bytes with the given fields and random filler bits
  function automatic void make_header(logic id, logic [3:0] sri, logic [12:0] len,
                                      logic [1:0] code);
    hb[0] = SYNC_BYTE;
    hb[1] = {SECOND_MATCH[7:4], id, 2'b00, 1'($urandom_range(1))};
    hb[2] = {2'($urandom_range(3)), sri, 2'($urandom_range(3))};
    hb[3] = {6'($urandom_range(63)), len[12:11]};
    hb[4] = len[10:3];
    hb[5] = {len[2:0], 5'($urandom_range(31))};
    hb[6] = {6'($urandom_range(63)), code};
    hb[7] = 8'($urandom_range(255));
  endfunction

  task automatic send_payload(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(255)));
  endtask

  task automatic send_frame(input logic id, input logic [3:0] sri, input logic [12:0] len,
                            input logic [1:0] code);
    make_header(id, sri, len, code);
    for (int k = 0; k < 8; k++) send_byte(hb[k]);
    send_payload(len - MIN_LEN);
  endtask

  // hold the sender off until every predicted beat has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.beats_due.size() != 0);
  endtask

  // random mix of good frames, noise, bad second bytes and bad headers
  task automatic run_random(input int unsigned n);
    int unsigned target, r, len_r;
    logic [12:0] len;
    logic [7:0]  b;
    target = items_sent + n;
    while (items_sent < target) begin
      r = $urandom_range(99);
      len_r = $urandom_range(99);
      len = (len_r < 90) ? 13'($urandom_range(8, 40)) : 13'($urandom_range(41, 300));
      if (r < 55) begin
        send_frame(1'($urandom_range(1)), 4'($urandom_range(11)), len,
                   2'($urandom_range(3)));
      end else if (r < 65) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end else if (r < 75) begin
        // sync followed by a second byte that fails the check
        do b = 8'($urandom_range(255)); while ((b & SECOND_MASK) == SECOND_MATCH);
        send_byte(SYNC_BYTE);
        send_byte(b);
      end else if (r < 85) begin
        // bad rate index or too short a length
        if ($urandom_range(1))
          make_header(1'($urandom_range(1)), 4'($urandom_range(12, 15)),
                      13'($urandom_range(8191)), 2'($urandom_range(3)));
        else
          make_header(1'($urandom_range(1)), 4'($urandom_range(11)), 13'($urandom_range(7)),
                      2'($urandom_range(3)));
        for (int k = 0; k < 8; k++) send_byte(hb[k]);
      end else begin
        // bad header whose tail holds a new sync, then the rest of that header
        make_header(1'($urandom_range(1)), 4'($urandom_range(12, 15)),
                    13'($urandom_range(8191)), 2'($urandom_range(3)));
        hb[6] = SYNC_BYTE;
        hb[7] = {SECOND_MATCH[7:4], 1'($urandom_range(1)), 2'b00, 1'($urandom_range(1))};
        for (int k = 0; k < 8; k++) send_byte(hb[k]);
        make_header(hb[7][3], 4'($urandom_range(11)), len, 2'($urandom_range(3)));
        for (int k = 2; k < 8; k++) send_byte(hb[k]);
        send_payload(len - MIN_LEN);
      end
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: noise, sync with a dropped sync as second byte, shortest frame
    // at the top rate index, one payload byte frame, too-short header
    send_byte(8'h00);
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_frame(1'b1, MAX_SRI, MIN_LEN, 2'd3);
    send_frame(1'b0, 4'd0, 13'd9, 2'd0);
    make_header(1'b0, 4'd3, 13'd7, 2'd1);
    for (int k = 0; k < 8; k++) send_byte(hb[k]);
    drain();

    // full speed
    run_random(110);
    drain();

    sender_idle_pct = 76;
    run_random(110);
    drain();

    sender_idle_pct = 0;
    recv_stall_pct = 76;
    run_random(110);
    drain();

    sender_idle_pct = 27;
    recv_stall_pct = 27;
    run_random(110);
    drain();

    repeat (16) @(posedge clk);
    $display("run: %0d bytes in, %0d frames decoded, %0d beats checked",
             sb.bytes_taken, sb.frames_ok, sb.beats_seen);
    $display("run: %0d headers rejected, %0d bad second bytes, %0d beats wrong",
             sb.hdr_rejects, sb.seconds_dropped, sb.errors);
    if (sb.errors == 0 && sb.beats_due.size() == 0)
      $display("tb_adts_frame_deframer_unit: PASS");
    else
      $display("tb_adts_frame_deframer_unit: FAIL");
    $finish;
  end

endmodule

### filelist.f
src/adts_pkg.sv
src/adts_datapath.sv
src/adts_controller.sv
src/adts_frame_deframer_unit.sv
src/adts_checker.sv
verif/tb_adts_frame_deframer_unit.sv
